@@ rtl/bgps_pkg.sv @@
package bgps_pkg;

    localparam int PHASE_BITS = 16;
    localparam int COUNT_BITS = 16;
    localparam int PHASE_W    = PHASE_BITS + 1;

    localparam logic [PHASE_W-1:0]    PHASE_ONE = PHASE_W'(1) << PHASE_BITS;
    localparam logic [COUNT_BITS-1:0] STEP_MAX  = '1;
    localparam logic [15:0]           TIMER_MAX = 16'hFFFF;

    // contact levels in 0.1 N
    localparam logic signed [15:0] AIRBORNE_FORCE  = 16'sd10;
    localparam logic signed [15:0] W2S_TOUCH_FORCE = 16'sd2000;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [1:0] {
        LEG_LEFT   = 2'd0,
        LEG_RIGHT  = 2'd1,
        LEG_DOUBLE = 2'd2
    } leg_t;

    typedef enum logic [1:0] {
        MOT_STAND = 2'd0,
        MOT_WALK  = 2'd1,
        MOT_W2S   = 2'd2
    } motion_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PHASE_INC      = 3'd0,
        REG_TD_THRESHOLD   = 3'd1,
        REG_MIN_TD_PHASE   = 3'd2,
        REG_TRANSFER_TICKS = 3'd3,
        REG_INIT_TICKS     = 3'd4,
        REG_MIN_XFER_FORCE = 3'd5,
        REG_OPTIONS        = 3'd6
    } cfg_reg_t;

    localparam int OPT_DST  = 0;
    localparam int OPT_INIT = 1;
    localparam int OPT_MEAS = 2;

    typedef struct packed {
        logic [15:0]        phase_increment;
        logic [14:0]        touchdown_force_threshold;
        logic [PHASE_W-1:0] min_touchdown_phase;
        logic [15:0]        transfer_ticks;
        logic [15:0]        initial_transfer_ticks;
        logic [14:0]        min_transfer_force;
        logic [2:0]         option_flags;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        phase_increment:           16'd164,
        touchdown_force_threshold: 15'd1000,
        min_touchdown_phase:       PHASE_W'(39322),
        transfer_ticks:            16'd100,
        initial_transfer_ticks:    16'd200,
        min_transfer_force:        15'd500,
        option_flags:              3'd0
    };

    typedef struct packed {
        leg_t                  support;
        leg_t                  pending;
        logic [PHASE_W-1:0]    phase_acc;
        logic [15:0]           transfer_elapsed;
        logic [COUNT_BITS-1:0] step_count;
        motion_t               motion;
        logic                  walk_latched;
        logic                  started;
        logic                  next_step_allowed;
        logic                  touched;
        logic                  first_transfer_done;
        logic                  swing_airborne;
    } gait_state_t;

    localparam gait_state_t STATE_RESET = '{
        support:             LEG_DOUBLE,
        pending:             LEG_LEFT,
        phase_acc:           '0,
        transfer_elapsed:    '0,
        step_count:          '0,
        motion:              MOT_STAND,
        walk_latched:        1'b0,
        started:             1'b0,
        next_step_allowed:   1'b0,
        touched:             1'b0,
        first_transfer_done: 1'b0,
        swing_airborne:      1'b0
    };

    typedef struct packed {
        logic signed [15:0] estimated_right_force;
        logic signed [15:0] estimated_left_force;
        logic signed [15:0] measured_right_force;
        logic signed [15:0] measured_left_force;
        logic               start_request;
        logic [1:0]         motion_command;
    } tick_in_t;

    typedef struct packed {
        logic        support_switched;
        logic [1:0]  motion_state_out;
        logic [15:0] step_total;
        logic [16:0] swing_phase;
        logic [1:0]  next_support_leg;
        logic [1:0]  support_leg;
    } tick_out_t;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

endpackage

@@ rtl/biped_gait_phase_scheduler_unit.sv @@
// Biped gait phase scheduler: one control tick per beat.
// Slave channel s_*: one beat carries the motion command, the start request and
// the measured and estimated vertical foot forces of a tick. Master channel m_*:
// one beat per input beat with support leg, next support leg, swing phase (Q1.16,
// clamped at one), step count, motion state and a support-switch flag.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write one register per cycle;
// write only while no tick is in flight.
// From input beat to result beat a tick passes through the input register, then
// through the gait update into the result register. Throughput is one tick per
// cycle while results are taken; the gait state update is combinational, so ticks
// can follow each other back to back.
// Reset (aresetn low, synchronous) loads default register values, puts the gait in
// double support and standing, and empties both the input and result registers.
// When m_tready is low the result holds; the input register still accepts one more
// beat, after which s_tready drops until the result is taken.
module biped_gait_phase_scheduler_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // motion_command[1:0], start_request[2], measured_left_force[18:3],
    // measured_right_force[34:19], estimated_left_force[50:35],
    // estimated_right_force[66:51], zero pad[71:67]
    input  logic [bgps_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // support_leg[1:0], next_support_leg[3:2], swing_phase[20:4],
    // step_total[36:21], motion_state_out[38:37], support_switched[39]
    output logic [bgps_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [bgps_pkg::CFG_ADDR_W-1:0]  cfg_index,
    input  logic [bgps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    bgps_pkg::cfg_t        cfg_reg;
    bgps_pkg::gait_state_t st_reg;
    bgps_pkg::gait_state_t st_next;
    bgps_pkg::tick_in_t    in_reg;
    bgps_pkg::tick_out_t   out_reg;
    bgps_pkg::tick_out_t   out_next;
    logic                  in_valid_reg;
    logic                  m_valid_reg;
    logic                  advance;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= bgps_pkg::CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bgps_pkg::REG_PHASE_INC:      cfg_reg.phase_increment <= cfg_wdata[15:0];
                bgps_pkg::REG_TD_THRESHOLD:   cfg_reg.touchdown_force_threshold <= cfg_wdata[14:0];
                bgps_pkg::REG_MIN_TD_PHASE:   cfg_reg.min_touchdown_phase <=
                                                  bgps_pkg::PHASE_W'(cfg_wdata);
                bgps_pkg::REG_TRANSFER_TICKS: cfg_reg.transfer_ticks <= cfg_wdata[15:0];
                bgps_pkg::REG_INIT_TICKS:     cfg_reg.initial_transfer_ticks <= cfg_wdata[15:0];
                bgps_pkg::REG_MIN_XFER_FORCE: cfg_reg.min_transfer_force <= cfg_wdata[14:0];
                bgps_pkg::REG_OPTIONS:        cfg_reg.option_flags <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= bgps_pkg::tick_in_t'(s_tdata[$bits(bgps_pkg::tick_in_t)-1:0]);
        end
    end

    bgps_step u_step (
        .cfg_i  (cfg_reg),
        .st_i   (st_reg),
        .tick_i (in_reg),
        .st_o   (st_next),
        .res_o  (out_next)
    );

    // gait state and result register advance together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= bgps_pkg::STATE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                st_reg <= st_next;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_phase_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.phase_acc <= bgps_pkg::PHASE_ONE)
        else $error("swing phase above one");

    a_pending_single: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.pending != bgps_pkg::LEG_DOUBLE)
        else $error("pending leg is double support");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("processed tick produced no result");

    a_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("waiting tick lost or changed");

    a_state_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(st_reg))
        else $error("gait state changed without a tick");
`endif

endmodule

@@ rtl/bgps_step.sv @@
module bgps_step (
    input  bgps_pkg::cfg_t        cfg_i,
    input  bgps_pkg::gait_state_t st_i,
    input  bgps_pkg::tick_in_t    tick_i,
    output bgps_pkg::gait_state_t st_o,
    output bgps_pkg::tick_out_t   res_o
);

    logic opt_dst;
    logic opt_init;
    logic opt_meas;
    logic signed [15:0] pend_force;
    logic signed [15:0] right_force;
    logic signed [15:0] left_force;
    logic signed [15:0] swing_force;
    logic [15:0] dur;
    logic [15:0] dphi;
    logic contact_ok;
    logic switched;
    bgps_pkg::leg_t next_leg;
    bgps_pkg::gait_state_t s;

    assign opt_dst  = cfg_i.option_flags[bgps_pkg::OPT_DST];
    assign opt_init = cfg_i.option_flags[bgps_pkg::OPT_INIT];
    assign opt_meas = cfg_i.option_flags[bgps_pkg::OPT_MEAS];

    assign right_force = opt_meas ? tick_i.measured_right_force : tick_i.estimated_right_force;
    assign left_force  = opt_meas ? tick_i.measured_left_force  : tick_i.estimated_left_force;

    always_comb begin
        s        = st_i;
        switched = 1'b0;
        dphi     = '0;
        dur      = '0;
        pend_force  = '0;
        swing_force = '0;
        contact_ok  = 1'b0;

        if (tick_i.start_request) begin
            s.walk_latched = 1'b1;
        end

        // enter first support from the previous motion state
        if (st_i.motion != bgps_pkg::MOT_STAND && st_i.step_count == '0 &&
            (!opt_init || st_i.first_transfer_done)) begin
            s.support = bgps_pkg::LEG_LEFT;
        end
        s.motion = (tick_i.motion_command == 2'd3) ? bgps_pkg::MOT_STAND
                                                   : bgps_pkg::motion_t'(tick_i.motion_command);

        if (s.motion == bgps_pkg::MOT_W2S) begin
            s.next_step_allowed = 1'b0;
            s.walk_latched      = 1'b0;
            if (s.touched) begin
                s.motion = bgps_pkg::MOT_STAND;
            end
        end

        unique case (s.motion)
            bgps_pkg::MOT_STAND: begin
                s.phase_acc         = '0;
                s.started           = 1'b0;
                s.next_step_allowed = 1'b0;
                s.step_count        = '0;
                if (opt_init) begin
                    s.first_transfer_done = 1'b0;
                    s.transfer_elapsed    = '0;
                    s.pending             = bgps_pkg::LEG_LEFT;
                    s.support             = bgps_pkg::LEG_DOUBLE;
                end
            end
            bgps_pkg::MOT_WALK: begin
                s.next_step_allowed = 1'b1;
                dphi = (opt_dst && s.support == bgps_pkg::LEG_DOUBLE) ? '0
                                                                      : cfg_i.phase_increment;
            end
            default: begin
                dphi = cfg_i.phase_increment;
            end
        endcase
        // phase is at most one here, so the sum fits without carry out
        s.phase_acc = s.phase_acc + bgps_pkg::PHASE_W'(dphi);
        if (s.next_step_allowed) begin
            s.touched = 1'b0;
        end

        if (!s.started && s.walk_latched) begin
            s.started = 1'b1;
            if (opt_init) begin
                s.pending             = bgps_pkg::LEG_LEFT;
                s.support             = bgps_pkg::LEG_DOUBLE;
                s.first_transfer_done = 1'b0;
                s.transfer_elapsed    = '0;
            end else begin
                s.support = bgps_pkg::LEG_LEFT;
            end
            switched = 1'b1;
        end

        // double-support transfer timer
        if (opt_dst && s.motion == bgps_pkg::MOT_WALK && s.started &&
            s.support == bgps_pkg::LEG_DOUBLE) begin
            pend_force = (s.pending == bgps_pkg::LEG_LEFT) ?
                         tick_i.measured_left_force : tick_i.measured_right_force;
            if (!opt_meas || pend_force >= $signed({1'b0, cfg_i.min_transfer_force})) begin
                if (s.transfer_elapsed != bgps_pkg::TIMER_MAX) begin
                    s.transfer_elapsed = s.transfer_elapsed + 16'd1;
                end
            end
            dur = (!s.first_transfer_done && cfg_i.initial_transfer_ticks != '0) ?
                  cfg_i.initial_transfer_ticks : cfg_i.transfer_ticks;
            if (s.transfer_elapsed >= dur) begin
                s.support = s.pending;
                if (opt_init) begin
                    s.first_transfer_done = 1'b1;
                end
                s.transfer_elapsed = '0;
                s.phase_acc        = '0;
                switched           = 1'b1;
            end
        end

        // swing foot touchdown
        swing_force = (s.support == bgps_pkg::LEG_LEFT) ? right_force : left_force;
        if (opt_meas && swing_force < bgps_pkg::AIRBORNE_FORCE) begin
            s.swing_airborne = 1'b1;
        end
        contact_ok = !opt_meas || s.swing_airborne;
        if (s.support == bgps_pkg::LEG_LEFT && contact_ok &&
            right_force >= $signed({1'b0, cfg_i.touchdown_force_threshold}) &&
            s.phase_acc >= cfg_i.min_touchdown_phase) begin
            if (s.next_step_allowed) begin
                s.pending        = bgps_pkg::LEG_RIGHT;
                s.support        = opt_dst ? bgps_pkg::LEG_DOUBLE : bgps_pkg::LEG_RIGHT;
                switched         = 1'b1;
                s.phase_acc      = '0;
                s.swing_airborne = 1'b0;
                if (s.step_count != bgps_pkg::STEP_MAX) begin
                    s.step_count = s.step_count + 1'b1;
                end
            end
        end else if (s.support == bgps_pkg::LEG_RIGHT && contact_ok &&
                     left_force >= $signed({1'b0, cfg_i.touchdown_force_threshold}) &&
                     s.phase_acc >= cfg_i.min_touchdown_phase) begin
            if (s.next_step_allowed) begin
                s.pending        = bgps_pkg::LEG_LEFT;
                s.support        = opt_dst ? bgps_pkg::LEG_DOUBLE : bgps_pkg::LEG_LEFT;
                switched         = 1'b1;
                s.phase_acc      = '0;
                s.swing_airborne = 1'b0;
                if (s.step_count != bgps_pkg::STEP_MAX) begin
                    s.step_count = s.step_count + 1'b1;
                end
            end
        end

        // walk-to-stand touchdown on estimated force
        if (!s.next_step_allowed) begin
            if (s.support == bgps_pkg::LEG_LEFT &&
                tick_i.estimated_right_force >= bgps_pkg::W2S_TOUCH_FORCE) begin
                s.touched = 1'b1;
                if (s.step_count != bgps_pkg::STEP_MAX) begin
                    s.step_count = s.step_count + 1'b1;
                end
                s.support = bgps_pkg::LEG_DOUBLE;
            end
            if (s.support == bgps_pkg::LEG_RIGHT &&
                tick_i.estimated_left_force >= bgps_pkg::W2S_TOUCH_FORCE) begin
                s.touched = 1'b1;
                if (s.step_count != bgps_pkg::STEP_MAX) begin
                    s.step_count = s.step_count + 1'b1;
                end
                s.support = bgps_pkg::LEG_DOUBLE;
            end
        end

        if (s.phase_acc >= bgps_pkg::PHASE_ONE) begin
            s.phase_acc = bgps_pkg::PHASE_ONE;
        end
    end

    always_comb begin
        unique case (s.support)
            bgps_pkg::LEG_LEFT:
                next_leg = (s.motion == bgps_pkg::MOT_W2S) ? bgps_pkg::LEG_DOUBLE
                                                           : bgps_pkg::LEG_RIGHT;
            bgps_pkg::LEG_RIGHT:
                next_leg = (s.motion == bgps_pkg::MOT_W2S) ? bgps_pkg::LEG_DOUBLE
                                                           : bgps_pkg::LEG_LEFT;
            default:
                next_leg = s.pending;
        endcase
    end

    assign st_o = s;

    assign res_o.support_leg      = s.support;
    assign res_o.next_support_leg = next_leg;
    assign res_o.swing_phase      = 17'(s.phase_acc);
    assign res_o.step_total       = 16'(s.step_count);
    assign res_o.motion_state_out = s.motion;
    assign res_o.support_switched = switched;

endmodule
